### src/sfmb_pkg.sv
// ----------------------------------------------------------------------------
// sfmb_pkg
// Shared types and constants for the SPI frame master with busy-release
// clocking: command codes, phases, beat structs and register layout.
// ----------------------------------------------------------------------------
package sfmb_pkg;

  localparam int unsigned FRAME_BITS = 26;
  localparam int unsigned PULSE_W    = 10;
  localparam int unsigned ADDR_W     = 7;
  localparam int unsigned BIT_CNT_W  = $clog2(FRAME_BITS + 1);
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [ADDR_W-1:0] LEVEL_ADDR_MAX = 7'h0F;
  localparam logic [ADDR_W-1:0] RESET_ADDR     = 7'h12;

  localparam logic [PULSE_W-1:0] PULSES_RST_INIT  = 10'd745;
  localparam logic [PULSE_W-1:0] PULSES_LVL_INIT  = 10'd22;
  localparam logic [PULSE_W-1:0] PULSES_NORM_INIT = 10'd4;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_RESET = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSES_RST  = 2'd0,
    REG_PULSES_LVL  = 2'd1,
    REG_PULSES_NORM = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BITS   = 3'd1,
    PH_TRAIL  = 3'd2,
    PH_PULSE  = 3'd3,
    PH_FINISH = 3'd4,
    PH_RSTREL = 3'd5
  } phase_e;

  typedef struct packed {
    action_e               action;
    logic [FRAME_BITS-1:0] frame_word;
    logic [ADDR_W-1:0]     target_address;
    logic                  serial_in;
  } sfmb_in_t;

  typedef struct packed {
    logic                  chip_select_n;
    logic                  serial_clock;
    logic                  serial_out;
    logic                  reset_n;
    logic                  active;
    logic [FRAME_BITS-1:0] read_word;
    logic                  read_valid;
    logic                  finished;
    logic                  refused;
  } sfmb_out_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulses_rst;
    logic [PULSE_W-1:0] pulses_lvl;
    logic [PULSE_W-1:0] pulses_norm;
  } sfmb_cfg_t;

endpackage

### src/sfmb_cfg.sv
// ----------------------------------------------------------------------------
// sfmb_cfg
// Pulse-count register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sfmb_cfg
  import sfmb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PULSE_W-1:0]   cfg_data_i,
  output sfmb_cfg_t            cfg_o
);

  sfmb_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulses_rst  <= PULSES_RST_INIT;
      cfg_q.pulses_lvl  <= PULSES_LVL_INIT;
      cfg_q.pulses_norm <= PULSES_NORM_INIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PULSES_RST:  cfg_q.pulses_rst  <= cfg_data_i;
        REG_PULSES_LVL:  cfg_q.pulses_lvl  <= cfg_data_i;
        REG_PULSES_NORM: cfg_q.pulses_norm <= cfg_data_i;
        default: ;  // unmapped index: drop
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/sfmb_engine.sv
// ----------------------------------------------------------------------------
// sfmb_engine
// Frame sequencer: holds the pin and shift state and advances it by one
// half clock period for each accepted beat, producing that beat's result.
// ----------------------------------------------------------------------------
module sfmb_engine
  import sfmb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  sfmb_in_t  beat_i,
  input  sfmb_cfg_t cfg_i,
  output sfmb_out_t res_o
);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

  phase_e                phase_q, phase_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic                  half_q, half_d;
  logic [FRAME_BITS-1:0] tx_q, tx_d;
  logic [FRAME_BITS-1:0] rx_q, rx_d;
  logic [PULSE_W-1:0]    pcnt_q, pcnt_d;
  logic [PULSE_W-1:0]    ptgt_q, ptgt_d;
  logic                  is_read_q, is_read_d;
  logic                  cs_n_q, cs_n_d;
  logic                  sclk_q, sclk_d;
  logic                  sdo_q, sdo_d;
  logic                  rst_n_q, rst_n_d;

  logic [PULSE_W-1:0]    pcnt_inc;
  logic [BIT_CNT_W-1:0]  rx_idx;
  logic                  cmd_start;

  assign pcnt_inc  = pcnt_q + PULSE_W'(1);
  assign rx_idx    = LAST_BIT - bit_cnt_q;
  assign cmd_start = (beat_i.action != ACT_TICK);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (beat_i.action == ACT_WRITE || beat_i.action == ACT_READ) begin
            phase_d = PH_BITS;
          end else if (beat_i.action == ACT_RESET) begin
            phase_d = PH_RSTREL;
          end
        end
        PH_BITS: begin
          if (half_q && bit_cnt_q == LAST_BIT) begin
            phase_d = PH_TRAIL;
          end
        end
        PH_TRAIL, PH_RSTREL: begin
          phase_d = (ptgt_q == '0) ? PH_FINISH : PH_PULSE;
        end
        PH_PULSE: begin
          if (half_q && pcnt_inc == ptgt_q) begin
            phase_d = PH_FINISH;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    bit_cnt_d = bit_cnt_q;
    half_d    = half_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    pcnt_d    = pcnt_q;
    ptgt_d    = ptgt_q;
    is_read_d = is_read_q;
    cs_n_d    = cs_n_q;
    sclk_d    = sclk_q;
    sdo_d     = sdo_q;
    rst_n_d   = rst_n_q;

    res_o            = '0;
    res_o.active     = 1'b1;

    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (beat_i.action == ACT_WRITE || beat_i.action == ACT_READ) begin
            cs_n_d    = 1'b0;
            sclk_d    = 1'b0;
            bit_cnt_d = '0;
            half_d    = 1'b0;
            if (beat_i.action == ACT_WRITE) begin
              is_read_d = 1'b0;
              tx_d      = beat_i.frame_word;
              if (beat_i.target_address <= LEVEL_ADDR_MAX) begin
                ptgt_d = cfg_i.pulses_lvl;
              end else if (beat_i.target_address == RESET_ADDR) begin
                ptgt_d = cfg_i.pulses_rst;
              end else begin
                ptgt_d = cfg_i.pulses_norm;
              end
            end else begin
              is_read_d = 1'b1;
              rx_d      = '0;
              ptgt_d    = cfg_i.pulses_norm;
            end
          end else if (beat_i.action == ACT_RESET) begin
            is_read_d = 1'b0;
            rst_n_d   = 1'b0;
            ptgt_d    = cfg_i.pulses_rst;
          end else begin
            res_o.active = 1'b0;
          end
        end
        PH_BITS: begin
          res_o.refused = cmd_start;
          if (!half_q) begin
            sclk_d = 1'b0;
            if (!is_read_q) begin
              sdo_d = tx_q[FRAME_BITS-1];
              tx_d  = {tx_q[FRAME_BITS-2:0], 1'b0};
            end
            half_d = 1'b1;
          end else begin
            sclk_d = 1'b1;
            if (is_read_q && beat_i.serial_in) begin
              rx_d[rx_idx] = 1'b1;
            end
            bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
            half_d    = 1'b0;
          end
        end
        PH_TRAIL: begin
          res_o.refused = cmd_start;
          sclk_d = 1'b0;
          pcnt_d = '0;
          half_d = 1'b0;
        end
        PH_RSTREL: begin
          res_o.refused = cmd_start;
          rst_n_d = 1'b1;
          pcnt_d  = '0;
          half_d  = 1'b0;
        end
        PH_PULSE: begin
          res_o.refused = cmd_start;
          cs_n_d = 1'b1;
          if (!half_q) begin
            sclk_d = 1'b0;
            half_d = 1'b1;
          end else begin
            sclk_d = 1'b1;
            pcnt_d = pcnt_inc;
            half_d = 1'b0;
          end
        end
        default: begin
          res_o.refused    = cmd_start;
          cs_n_d           = 1'b1;
          sclk_d           = 1'b0;
          res_o.active     = 1'b0;
          res_o.finished   = 1'b1;
          res_o.read_valid = is_read_q;
          half_d           = 1'b0;
        end
      endcase
    end

    res_o.chip_select_n = cs_n_d;
    res_o.serial_clock  = sclk_d;
    res_o.serial_out    = sdo_d;
    res_o.reset_n       = rst_n_d;
    res_o.read_word     = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= '0;
      half_q    <= 1'b0;
      tx_q      <= '0;
      rx_q      <= '0;
      pcnt_q    <= '0;
      ptgt_q    <= '0;
      is_read_q <= 1'b0;
      cs_n_q    <= 1'b1;
      sclk_q    <= 1'b0;
      sdo_q     <= 1'b0;
      rst_n_q   <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      half_q    <= half_d;
      tx_q      <= tx_d;
      rx_q      <= rx_d;
      pcnt_q    <= pcnt_d;
      ptgt_q    <= ptgt_d;
      is_read_q <= is_read_d;
      cs_n_q    <= cs_n_d;
      sclk_q    <= sclk_d;
      sdo_q     <= sdo_d;
      rst_n_q   <= rst_n_d;
    end
  end

endmodule

### src/sfmb_outreg.sv
// ----------------------------------------------------------------------------
// sfmb_outreg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module sfmb_outreg
  import sfmb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  sfmb_out_t res_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output sfmb_out_t out_beat_o,
  output logic      full_stall_o
);

  logic      valid_q;
  sfmb_out_t beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beat_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_beat_o   = beat_q;
  assign full_stall_o = valid_q & out_stall_i;

endmodule

### src/spi_frame_master_busy_clocking_top.sv
// ----------------------------------------------------------------------------
// spi_frame_master_busy_clocking_top
// Pin-level SPI master for 26-bit frames with busy-release clock pulses,
// advanced one half clock period per input beat.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------
//   in       | sink      | in_valid_i / in_stall_o | sfmb_in_t  (command/tick)
//   out      | source    | out_valid_o/out_stall_i | sfmb_out_t (pin levels)
//   cfg      | sink      | cfg_we_i                | pulse-count registers
//
// Every accepted input beat yields exactly one result beat. The sequencer
// updates its state in the cycle a beat is accepted and the result lands in
// the output register on the same edge, so a new beat can be accepted every
// cycle while in_stall_o is low; out_valid_o rises the cycle after acceptance.
// in_stall_o rises only while the output register holds a beat the consumer
// is stalling. Reset idles the pins (chip select high, clock low, data low,
// device reset high) and reloads the pulse counts to 745, 22 and 4.
// ----------------------------------------------------------------------------
module spi_frame_master_busy_clocking_top
  import sfmb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfmb_in_t             in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfmb_out_t            out_beat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PULSE_W-1:0]   cfg_data_i
);

  sfmb_cfg_t cfg;
  sfmb_out_t res;
  logic      step;
  logic      full_stall;

  // accept a beat whenever the result register can take its result
  assign step       = in_valid_i & ~full_stall;
  assign in_stall_o = full_stall;

  sfmb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfmb_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (in_beat_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  sfmb_outreg u_outreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .res_i        (res),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_beat_o   (out_beat_o),
    .full_stall_o (full_stall)
  );

endmodule

### tb/tb_spi_frame_master_busy_clocking_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_frame_master_busy_clocking_top
// Self-checking bench for the 26-bit SPI frame master with busy-release
// clocking. A directed table covers the reset pulse counts, the address
// classes, full-scale words, reads of all ones and all zeros, the device
// reset and commands refused while busy. Random well-formed command streams
// follow under three idling mixes, then a short run with every pulse count
// at zero. Every pin snapshot is checked against a cycle-level predictor.
// ----------------------------------------------------------------------------
module tb_spi_frame_master_busy_clocking_top;
  import sfmb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned RAND_BEATS  = 80;    // per random phase
  localparam int unsigned DFLT_ROWS   = 3;     // rows run with reset counts
  localparam int unsigned N_ROWS      = 16;

  // Pin snapshot right after reset, and the first beat of a write from reset.
  localparam sfmb_out_t IDLE_PINS = '{chip_select_n: 1'b1, serial_clock: 1'b0,
    serial_out: 1'b0, reset_n: 1'b1, active: 1'b0, read_word: '0,
    read_valid: 1'b0, finished: 1'b0, refused: 1'b0};
  localparam sfmb_out_t WRITE_START_PINS = '{chip_select_n: 1'b0,
    serial_clock: 1'b0, serial_out: 1'b0, reset_n: 1'b1, active: 1'b1,
    read_word: '0, read_valid: 1'b0, finished: 1'b0, refused: 1'b0};

  typedef struct packed {
    sfmb_in_t  beat;
    logic      drain;   // tick on until the master is idle again
    logic      typed;   // want holds a hand-written expectation
    sfmb_out_t want;
  } dir_row_t;

  // Directed stimulus. The first DFLT_ROWS rows run on the reset pulse
  // counts (745, 22, 4); the rest run after the counts drop to 3, 0, 1.
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{'{ACT_TICK,  26'h0000000, 7'h00, 1'b0}, 1'b0, 1'b1, IDLE_PINS},
    '{'{ACT_WRITE, 26'h2000000, 7'h00, 1'b0}, 1'b1, 1'b1, WRITE_START_PINS},
    '{'{ACT_READ,  26'h0000000, 7'h00, 1'b1}, 1'b1, 1'b0, '0},
    // level address top edge, zero pulse count
    '{'{ACT_WRITE, 26'h3FFFFFF, 7'h0F, 1'b0}, 1'b1, 1'b0, '0},
    '{'{ACT_WRITE, 26'h0000000, 7'h10, 1'b1}, 1'b1, 1'b0, '0},
    '{'{ACT_WRITE, 26'h2AAAAAA, 7'h12, 1'b0}, 1'b1, 1'b0, '0},
    '{'{ACT_WRITE, 26'h1555555, 7'h7F, 1'b1}, 1'b1, 1'b0, '0},
    '{'{ACT_READ,  26'h3FFFFFF, 7'h7F, 1'b1}, 1'b1, 1'b0, '0},
    '{'{ACT_READ,  26'h0000000, 7'h00, 1'b0}, 1'b1, 1'b0, '0},
    '{'{ACT_RESET, 26'h1555555, 7'h12, 1'b1}, 1'b1, 1'b0, '0},
    // a write starts on the idle master; the commands landing on it while busy are refused
    '{'{ACT_WRITE, 26'h2000000, 7'h11, 1'b0}, 1'b0, 1'b0, '0},
    '{'{ACT_READ,  26'h0000000, 7'h00, 1'b1}, 1'b0, 1'b0, '0},
    '{'{ACT_RESET, 26'h0000000, 7'h00, 1'b0}, 1'b0, 1'b0, '0},
    '{'{ACT_WRITE, 26'h3FFFFFF, 7'h05, 1'b1}, 1'b1, 1'b0, '0},
    '{'{ACT_TICK,  26'h3FFFFFF, 7'h7F, 1'b1}, 1'b0, 1'b0, '0},
    '{'{ACT_READ,  26'h2AAAAAA, 7'h12, 1'b1}, 1'b1, 1'b0, '0}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  sfmb_in_t             in_beat_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  sfmb_out_t            out_beat_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_PULSES_RST;
  logic [PULSE_W-1:0]   cfg_data_i  = '0;

  spi_frame_master_busy_clocking_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Pin predictor: its own copy of the sequencer state and pulse counts.
  // --------------------------------------------------------------------------
  phase_e                pr_phase   = PH_IDLE;
  logic [BIT_CNT_W-1:0]  pr_bits    = '0;
  logic                  pr_half    = 1'b0;
  logic [FRAME_BITS-1:0] pr_tx      = '0;
  logic [FRAME_BITS-1:0] pr_rx      = '0;
  logic [PULSE_W-1:0]    pr_pulses  = '0;
  logic [PULSE_W-1:0]    pr_target  = '0;
  logic                  pr_is_read = 1'b0;
  logic                  pin_cs_n   = 1'b1;
  logic                  pin_sclk   = 1'b0;
  logic                  pin_mosi   = 1'b0;
  logic                  pin_rst_n  = 1'b1;
  logic [PULSE_W-1:0]    cnt_rst    = PULSES_RST_INIT;
  logic [PULSE_W-1:0]    cnt_lvl    = PULSES_LVL_INIT;
  logic [PULSE_W-1:0]    cnt_norm   = PULSES_NORM_INIT;

  // Expected pin snapshots, oldest first.
  sfmb_out_t pin_levels_q [$];

  int unsigned errors        = 0;
  int unsigned beats_sent    = 0;
  int unsigned snaps_checked = 0;
  int unsigned ops_finished  = 0;
  int unsigned reads_done    = 0;
  int unsigned refused_seen  = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_pct      = 30;
  int unsigned recv_pct      = 69;

  // Arm the busy-release train; a zero count goes straight to the end tick.
  function automatic void start_release_train();
    pr_pulses = '0;
    pr_half   = 1'b0;
    pr_phase  = (pr_target == '0) ? PH_FINISH : PH_PULSE;
  endfunction

  // Advance one half clock period and return the pins for this beat.
  function automatic sfmb_out_t advance_pins(input sfmb_in_t b);
    sfmb_out_t o;
    o        = '0;
    o.active = 1'b1;
    if (pr_phase == PH_IDLE) begin
      if (b.action == ACT_WRITE || b.action == ACT_READ) begin
        pin_cs_n = 1'b0;
        pin_sclk = 1'b0;
        pr_bits  = '0;
        pr_half  = 1'b0;
        pr_phase = PH_BITS;
        if (b.action == ACT_WRITE) begin
          pr_is_read = 1'b0;
          pr_tx      = b.frame_word;
          if (b.target_address <= LEVEL_ADDR_MAX) pr_target = cnt_lvl;
          else if (b.target_address == RESET_ADDR) pr_target = cnt_rst;
          else pr_target = cnt_norm;
        end else begin
          pr_is_read = 1'b1;
          pr_rx      = '0;
          pr_target  = cnt_norm;
        end
      end else if (b.action == ACT_RESET) begin
        pr_is_read = 1'b0;
        pin_rst_n  = 1'b0;
        pr_target  = cnt_rst;
        pr_phase   = PH_RSTREL;
      end else begin
        o.active = 1'b0;
      end
    end else begin
      o.refused = (b.action != ACT_TICK);
      case (pr_phase)
        PH_BITS: begin
          if (!pr_half) begin
            pin_sclk = 1'b0;
            if (!pr_is_read) begin
              pin_mosi = pr_tx[FRAME_BITS-1];
              pr_tx    = pr_tx << 1;
            end
            pr_half = 1'b1;
          end else begin
            pin_sclk = 1'b1;
            if (pr_is_read && b.serial_in) begin
              pr_rx[BIT_CNT_W'(FRAME_BITS - 1) - pr_bits] = 1'b1;
            end
            pr_bits = pr_bits + BIT_CNT_W'(1);
            pr_half = 1'b0;
            if (pr_bits >= BIT_CNT_W'(FRAME_BITS)) pr_phase = PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          pin_sclk = 1'b0;
          start_release_train();
        end
        PH_RSTREL: begin
          pin_rst_n = 1'b1;
          start_release_train();
        end
        PH_PULSE: begin
          pin_cs_n = 1'b1;
          if (!pr_half) begin
            pin_sclk = 1'b0;
            pr_half  = 1'b1;
          end else begin
            pin_sclk  = 1'b1;
            pr_pulses = pr_pulses + PULSE_W'(1);
            pr_half   = 1'b0;
            if (pr_pulses == pr_target) pr_phase = PH_FINISH;
          end
        end
        default: begin
          pin_cs_n     = 1'b1;
          pin_sclk     = 1'b0;
          o.active     = 1'b0;
          o.finished   = 1'b1;
          o.read_valid = pr_is_read;
          pr_half      = 1'b0;
          pr_phase     = PH_IDLE;
        end
      endcase
    end
    o.chip_select_n = pin_cs_n;
    o.serial_clock  = pin_sclk;
    o.serial_out    = pin_mosi;
    o.reset_n       = pin_rst_n;
    o.read_word     = pr_rx;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Random payload around a given action; the address leans toward the three
  // pulse-count classes so each one is hit often.
  function automatic sfmb_in_t random_beat(input action_e act);
    sfmb_in_t b;
    b.action     = act;
    b.frame_word = FRAME_BITS'($urandom());
    case ($urandom_range(0, 3))
      0:       b.target_address = ADDR_W'($urandom_range(0, 15));
      1:       b.target_address = RESET_ADDR;
      2:       b.target_address = ADDR_W'($urandom_range(16, 127));
      default: b.target_address = ADDR_W'($urandom());
    endcase
    b.serial_in = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // Present one beat, hold it through stalls, and log its expected pins at
  // the accepting edge. Returns right after that edge.
  task automatic send_beat(input sfmb_in_t b);
    int unsigned gap;
    gap = 0;
    while (gap < 8 && $urandom_range(0, 99) < send_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pin_levels_q.push_back(advance_pins(b));
    beats_sent++;
  endtask

  // Tick until the predicted sequencer is back at idle.
  task automatic tick_until_idle(input bit fixed_sin, input logic sin_lvl);
    sfmb_in_t b;
    while (pr_phase != PH_IDLE) begin
      b = random_beat(ACT_TICK);
      if (fixed_sin) b.serial_in = sin_lvl;
      send_beat(b);
    end
  endtask

  // Write all three pulse counts on an idle master with nothing in flight.
  task automatic load_pulse_counts(input logic [PULSE_W-1:0] rst_cnt,
                                   input logic [PULSE_W-1:0] lvl_cnt,
                                   input logic [PULSE_W-1:0] norm_cnt);
    in_valid_i <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PULSES_RST;
    cfg_data_i <= rst_cnt;
    @(posedge clk_i);
    cfg_idx_i  <= REG_PULSES_LVL;
    cfg_data_i <= lvl_cnt;
    @(posedge clk_i);
    cfg_idx_i  <= REG_PULSES_NORM;
    cfg_data_i <= norm_cnt;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cnt_rst  = rst_cnt;
    cnt_lvl  = lvl_cnt;
    cnt_norm = norm_cnt;
  endtask

  // Random stream: mostly commands while idle, mostly ticks while busy with a
  // few commands thrown in to be refused.
  task automatic run_random_phase();
    sfmb_in_t b;
    int unsigned r;
    for (int unsigned n = 0; n < RAND_BEATS; n++) begin
      if (pr_phase == PH_IDLE) begin
        r = $urandom_range(0, 99);
        if (r < 45) b = random_beat(ACT_WRITE);
        else if (r < 75) b = random_beat(ACT_READ);
        else if (r < 85) b = random_beat(ACT_RESET);
        else b = random_beat(ACT_TICK);
      end else if ($urandom_range(0, 99) < 4) begin
        b = random_beat(action_e'($urandom_range(1, 3)));
      end else begin
        b = random_beat(ACT_TICK);
      end
      send_beat(b);
    end
    tick_until_idle(1'b0, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, then check each accepted beat in order.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_pct);
  end

  task automatic compare_field(input string name, input logic [FRAME_BITS-1:0] want,
                               input logic [FRAME_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    sfmb_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pin_levels_q.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        want = pin_levels_q.pop_front();
        compare_field("chip_select_n", FRAME_BITS'(want.chip_select_n),
                      FRAME_BITS'(out_beat_o.chip_select_n));
        compare_field("serial_clock", FRAME_BITS'(want.serial_clock),
                      FRAME_BITS'(out_beat_o.serial_clock));
        compare_field("serial_out", FRAME_BITS'(want.serial_out),
                      FRAME_BITS'(out_beat_o.serial_out));
        compare_field("reset_n", FRAME_BITS'(want.reset_n),
                      FRAME_BITS'(out_beat_o.reset_n));
        compare_field("active", FRAME_BITS'(want.active),
                      FRAME_BITS'(out_beat_o.active));
        compare_field("read_word", want.read_word, out_beat_o.read_word);
        compare_field("read_valid", FRAME_BITS'(want.read_valid),
                      FRAME_BITS'(out_beat_o.read_valid));
        compare_field("finished", FRAME_BITS'(want.finished),
                      FRAME_BITS'(out_beat_o.finished));
        compare_field("refused", FRAME_BITS'(want.refused),
                      FRAME_BITS'(out_beat_o.refused));
        snaps_checked++;
        if (want.finished) ops_finished++;
        if (want.read_valid) reads_done++;
        if (want.refused) refused_seen++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed table, three random phases, zero counts.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; swap in short counts once the reset counts are seen.
    for (int unsigned i = 0; i < N_ROWS; i++) begin
      if (i == DFLT_ROWS) load_pulse_counts(10'd3, 10'd0, 10'd1);
      send_beat(DIR_ROWS[i].beat);
      // Hand-written rows override the predictor for their own beat.
      if (DIR_ROWS[i].typed) pin_levels_q[pin_levels_q.size()-1] = DIR_ROWS[i].want;
      if (DIR_ROWS[i].drain) tick_until_idle(1'b1, DIR_ROWS[i].beat.serial_in);
    end
    tick_until_idle(1'b0, 1'b0);

    // Sender idles lightly, receiver stalls heavily.
    load_pulse_counts(PULSE_W'($urandom_range(0, 5)), PULSE_W'($urandom_range(0, 5)),
                      PULSE_W'($urandom_range(0, 5)));
    run_random_phase();

    // Swap the pressure.
    send_pct = 69;
    recv_pct = 30;
    load_pulse_counts(PULSE_W'($urandom_range(0, 5)), PULSE_W'($urandom_range(0, 5)),
                      PULSE_W'($urandom_range(0, 5)));
    run_random_phase();

    // Back to back, no idling on either side.
    send_pct = 0;
    recv_pct = 0;
    load_pulse_counts(PULSE_W'($urandom_range(0, 5)), PULSE_W'($urandom_range(0, 5)),
                      PULSE_W'($urandom_range(0, 5)));
    run_random_phase();

    // Zero counts: every train skipped, after a device reset, a level write
    // and a read.
    load_pulse_counts(10'd0, 10'd0, 10'd0);
    send_beat(random_beat(ACT_RESET));
    tick_until_idle(1'b0, 1'b0);
    send_beat('{ACT_WRITE, 26'h2AAAAAA, 7'h03, 1'b0});
    tick_until_idle(1'b0, 1'b0);
    send_beat(random_beat(ACT_READ));
    tick_until_idle(1'b0, 1'b0);

    // Drop valid, let the last snapshots drain, then settle.
    in_valid_i <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Run: %0d beats driven, %0d pin snapshots checked", beats_sent, snaps_checked);
    $display("Run: %0d operations ended (%0d reads), %0d commands refused while busy",
             ops_finished, reads_done, refused_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
